// ===== rtl/crt_controller_type0_defines.svh =====
// Assertion macros shared by the controller's checker
`ifndef CRT_CONTROLLER_TYPE0_DEFINES_SVH
`define CRT_CONTROLLER_TYPE0_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define CRTC0_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define CRTC0_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/crtc0_pkg.sv =====
// Shared types and constants of the CRT controller
`default_nettype none
package crtc0_pkg;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_SELECT = 2'd1,
    CMD_WRITE  = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    SL_IDLE = 2'd0,
    SL_ONE  = 2'd1,
    SL_TWO  = 2'd2
  } sl_t;

  typedef enum logic [1:0] {
    MR_IDLE = 2'd0,
    MR_ONE  = 2'd1,
    MR_TWO  = 2'd2
  } mr_t;

  localparam logic [1:0] MON_NONE  = 2'd0;
  localparam logic [1:0] MON_START = 2'd1;
  localparam logic [1:0] MON_END   = 2'd2;

  localparam logic [1:0] CHK_NONE = 2'd0;
  localparam logic [1:0] CHK_MIN  = 2'd1;
  localparam logic [1:0] CHK_MAX  = 2'd2;

  localparam logic [3:0] R_HTOTAL = 4'd0;
  localparam logic [3:0] R_HDISP  = 4'd1;
  localparam logic [3:0] R_HSPOS  = 4'd2;
  localparam logic [3:0] R_SYNCW  = 4'd3;
  localparam logic [3:0] R_VTOTAL = 4'd4;
  localparam logic [3:0] R_VADJ   = 4'd5;
  localparam logic [3:0] R_VDISP  = 4'd6;
  localparam logic [3:0] R_VSPOS  = 4'd7;
  localparam logic [3:0] R_SKEW   = 4'd8;
  localparam logic [3:0] R_MAXRAS = 4'd9;
  localparam logic [3:0] R_CURST  = 4'd10;
  localparam logic [3:0] R_CUREND = 4'd11;
  localparam logic [3:0] R_ADDRH  = 4'd12;
  localparam logic [3:0] R_ADDRL  = 4'd13;
  localparam logic [3:0] R_CURH   = 4'd14;
  localparam logic [3:0] R_CURL   = 4'd15;

  localparam logic [4:0] BLANK_LINES = 5'd26;

  localparam logic [7:0] REG_RESET [16] = '{
    8'd63, 8'd40, 8'd46, 8'h8e, 8'd38, 8'd0, 8'd25, 8'd30,
    8'd0, 8'd7, 8'd0, 8'd0, 8'h30, 8'd0, 8'd0, 8'd0
  };

  typedef struct packed {
    logic in_hsync;
    logic had_hsync;
    logic in_mon_hsync;
    logic in_vsync;
    logic in_vta;
    logic start_vta;
    logic res_char;
    logic res_frame;
    logic res_next;
    logic res_scan;
    logic res_vsync;
    logic r7_match;
    logic r9_match;
  } flags_t;

endpackage
`default_nettype wire

// ===== rtl/crtc0_if.sv =====
// Valid/ready channels for the controller's command and result words
`default_nettype none
interface crtc0_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] data;

  modport source (output valid, output command, output data, input ready);
  modport sink (input valid, input command, input data, output ready);
endinterface

interface crtc0_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_value;
  logic [15:0] video_address;
  logic        hsync_active;
  logic        vsync_active;
  logic        vertical_enable;
  logic [1:0]  horizontal_enable;
  logic [4:0]  blank_lines_left;
  logic [1:0]  monitor_hsync_event;
  logic        hsync_end_pulse;
  logic        vsync_start_pulse;
  logic        mode_change_pulse;
  logic [1:0]  scanline_check;

  modport source (output valid, output read_value, output video_address,
                  output hsync_active, output vsync_active, output vertical_enable,
                  output horizontal_enable, output blank_lines_left,
                  output monitor_hsync_event, output hsync_end_pulse,
                  output vsync_start_pulse, output mode_change_pulse,
                  output scanline_check, input ready);
  modport sink (input valid, input read_value, input video_address,
                input hsync_active, input vsync_active, input vertical_enable,
                input horizontal_enable, input blank_lines_left,
                input monitor_hsync_event, input hsync_end_pulse,
                input vsync_start_pulse, input mode_change_pulse,
                input scanline_check, output ready);
endinterface
`default_nettype wire

// ===== rtl/crt_controller_type0.sv =====
// A result word is registered when its command word is accepted and appears in the cycle after.
// Throughput: one command word per cycle while the result side takes words; the next-state logic is a single
//   combinational pass from the state registers to the state and result registers.
// The result register decouples the sides: a new word enters in the cycle the last is taken.
// Reset (rst_n low, synchronous) loads the power-on register set and clears
//   all counters, flags and the result valid.
`default_nettype none
module crt_controller_type0 (
  input  wire logic clk,
  input  wire logic rst_n,
  crtc0_in_if.sink    in_ch,
  crtc0_out_if.source out_ch
);
  import crtc0_pkg::*;

  // State registers
  logic [7:0]  regs_r [16];
  logic [7:0]  regs_nxt [16];
  logic [4:0]  sel_r, sel_nxt;
  logic [7:0]  char_r, char_nxt;
  logic [4:0]  ras_r, ras_nxt;
  logic [6:0]  line_r, line_nxt;
  logic [3:0]  hsw_r, hsw_nxt;
  logic [4:0]  vswc_r, vswc_nxt;
  logic [13:0] la_cur_r, la_cur_nxt;
  logic [13:0] la_next_r, la_next_nxt;
  logic [13:0] la_req_r, la_req_nxt;
  logic [2:0]  rbase_r, rbase_nxt;
  flags_t      fl_r, fl_nxt;
  sl_t         sl_r, sl_nxt;
  mr_t         mr_r, mr_nxt;
  logic [7:0]  last_end_r, last_end_nxt;
  logic [1:0]  h_start_r, h_start_nxt;
  logic [7:0]  h_end_r, h_end_nxt;
  logic [4:0]  adjust_r, adjust_nxt;
  logic        pend_v_r, pend_v_nxt;
  logic        cur_v_r, cur_v_nxt;
  logic [1:0]  pend_h_r, pend_h_nxt;
  logic [1:0]  cur_h_r, cur_h_nxt;
  logic [4:0]  blank_r, blank_nxt;
  logic [15:0] video_r, video_nxt;

  // Per-word results
  logic [7:0]  rv;
  logic [1:0]  ev_mon;
  logic        ev_hend;
  logic        ev_vstart;
  logic        ev_mode;
  logic [1:0]  ev_check;
  logic        new_scan;
  logic        ras_match;
  logic [1:0]  skew;
  logic [4:0]  vsw;
  logic [13:0] fetch_sum;
  logic [7:0]  wr_val;

  // Result register
  logic        out_valid_r;
  logic [7:0]  out_rv_r;
  logic [15:0] out_video_r;
  logic        out_hsync_r;
  logic        out_vsync_r;
  logic        out_ven_r;
  logic [1:0]  out_hen_r;
  logic [4:0]  out_blank_r;
  logic [1:0]  out_mon_r;
  logic        out_hend_r;
  logic        out_vstart_r;
  logic        out_mode_r;
  logic [1:0]  out_check_r;

  logic accept;
  cmd_t cmd;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign cmd         = cmd_t'(in_ch.command);
  assign wr_val      = in_ch.data;
  assign fetch_sum   = la_cur_r + {6'd0, char_r};
  assign vsw         = (regs_r[R_SYNCW][7:4] == 4'd0) ? 5'd16 : {1'b0, regs_r[R_SYNCW][7:4]};

  // Compute the next state and the result word for one command
  always_comb begin
    regs_nxt     = regs_r;
    sel_nxt      = sel_r;
    char_nxt     = char_r;
    ras_nxt      = ras_r;
    line_nxt     = line_r;
    hsw_nxt      = hsw_r;
    vswc_nxt     = vswc_r;
    la_cur_nxt   = la_cur_r;
    la_next_nxt  = la_next_r;
    la_req_nxt   = la_req_r;
    rbase_nxt    = rbase_r;
    fl_nxt       = fl_r;
    sl_nxt       = sl_r;
    mr_nxt       = mr_r;
    last_end_nxt = last_end_r;
    h_start_nxt  = h_start_r;
    h_end_nxt    = h_end_r;
    adjust_nxt   = adjust_r;
    pend_v_nxt   = pend_v_r;
    cur_v_nxt    = cur_v_r;
    pend_h_nxt   = pend_h_r;
    cur_h_nxt    = cur_h_r;
    blank_nxt    = blank_r;
    video_nxt    = video_r;
    rv           = 8'd0;
    ev_mon       = MON_NONE;
    ev_hend      = 1'b0;
    ev_vstart    = 1'b0;
    ev_mode      = 1'b0;
    ev_check     = CHK_NONE;
    new_scan     = 1'b0;
    ras_match    = 1'b0;
    skew         = regs_r[R_SKEW][5:4];

    case (cmd)
      CMD_TICK: begin
        // Latch the fetch address and the display timing
        video_nxt = {fetch_sum[13:12], rbase_r, fetch_sum[9:0], 1'b0};
        cur_v_nxt = pend_v_r;
        cur_h_nxt = pend_h_r;

        // Advance the character counter
        if (char_r == regs_r[R_HTOTAL]) begin
          last_end_nxt = char_r;
          new_scan     = 1'b1;
          char_nxt     = 8'd0;
        end else begin
          char_nxt = char_r + 8'd1;
        end

        // Last character of the line
        if (char_nxt == regs_r[R_HTOTAL]) begin
          fl_nxt.res_char = ({3'd0, ras_nxt} == regs_r[R_MAXRAS]);
          if (fl_nxt.res_next) begin
            fl_nxt.res_next  = 1'b0;
            fl_nxt.res_frame = 1'b1;
          end
          if (fl_nxt.start_vta) begin
            fl_nxt.start_vta = 1'b0;
            fl_nxt.in_vta    = 1'b1;
          end
          if (fl_nxt.in_vta)
            fl_nxt.res_scan = ({3'd0, ras_nxt} == regs_r[R_MAXRAS]) &&
                              ({1'b0, line_nxt} == regs_r[R_VTOTAL]);
        end

        // Capture the next line's start address
        if (char_nxt == regs_r[R_HDISP] && {3'd0, ras_nxt} == regs_r[R_MAXRAS])
          la_next_nxt = la_cur_r + {6'd0, char_nxt};

        // Horizontal sync
        if (fl_nxt.in_hsync || char_nxt == regs_r[R_HSPOS]) begin
          if (!fl_nxt.in_hsync) begin
            fl_nxt.in_hsync  = 1'b1;
            fl_nxt.had_hsync = 1'b1;
            hsw_nxt          = 4'd0;
          end
          if (hsw_nxt == regs_r[R_SYNCW][3:0]) begin
            ev_hend         = 1'b1;
            fl_nxt.in_hsync = 1'b0;
            if (blank_nxt != 5'd0) blank_nxt = blank_nxt - 5'd1;
            if (fl_nxt.had_hsync) begin
              fl_nxt.had_hsync = 1'b0;
              ev_mode          = 1'b1;
            end
            if (fl_nxt.in_mon_hsync) begin
              fl_nxt.in_mon_hsync = 1'b0;
              ev_mon              = MON_END;
            end
          end else begin
            hsw_nxt = hsw_nxt + 4'd1;
            if (hsw_nxt == 4'd3) begin
              fl_nxt.in_mon_hsync = 1'b1;
              ev_mon              = MON_START;
            end else if (hsw_nxt == 4'd7) begin
              if (fl_nxt.had_hsync) begin
                fl_nxt.had_hsync = 1'b0;
                ev_mode          = 1'b1;
              end
              fl_nxt.in_mon_hsync = 1'b0;
              ev_mon              = MON_END;
            end
          end
        end

        // Advance the delay slots
        case (sl_nxt)
          SL_ONE: sl_nxt = SL_TWO;
          SL_TWO: begin
            adjust_nxt = regs_r[R_VADJ][4:0];
            sl_nxt     = SL_IDLE;
          end
          default: ;
        endcase
        case (mr_nxt)
          MR_ONE: begin
            if ({3'd0, ras_nxt} == regs_r[R_MAXRAS] &&
                {1'b0, line_nxt} == regs_r[R_VTOTAL]) begin
              fl_nxt.in_vta    = 1'b0;
              fl_nxt.start_vta = 1'b1;
            end else begin
              fl_nxt.start_vta = 1'b0;
            end
            mr_nxt = MR_TWO;
          end
          MR_TWO: begin
            if (fl_nxt.start_vta && {1'b0, line_nxt} == regs_r[R_VTOTAL] &&
                regs_r[R_VADJ] == 8'd0)
              fl_nxt.res_next = 1'b1;
            mr_nxt = MR_IDLE;
          end
          default: ;
        endcase

        // New scan line
        if (new_scan) begin
          la_cur_nxt = la_next_nxt;
          if (fl_nxt.in_vsync) begin
            vswc_nxt = vswc_nxt + 5'd1;
            if (vswc_nxt == vsw) begin
              vswc_nxt         = 5'd0;
              fl_nxt.res_vsync = 1'b1;
            end
          end

          if (fl_nxt.res_frame) begin
            // Restart the frame
            fl_nxt.in_vta    = 1'b0;
            fl_nxt.res_frame = 1'b0;
            fl_nxt.res_scan  = 1'b0;
            fl_nxt.res_char  = 1'b0;
            ras_nxt          = 5'd0;
            rbase_nxt        = 3'd0;
            line_nxt         = 7'd0;
            pend_v_nxt       = 1'b1;
            la_cur_nxt       = la_req_nxt;
            la_next_nxt      = la_req_nxt;
            if ({1'b0, line_nxt} == regs_r[R_VDISP]) pend_v_nxt = 1'b0;
            if ({1'b0, line_nxt} == regs_r[R_VSPOS]) begin
              if (last_end_nxt >= 8'd2 && !fl_nxt.r7_match) begin
                fl_nxt.res_vsync = 1'b0;
                if (!fl_nxt.in_vsync) begin
                  vswc_nxt        = 5'd0;
                  fl_nxt.in_vsync = 1'b1;
                  blank_nxt       = BLANK_LINES;
                  ev_vstart       = 1'b1;
                end
              end
              fl_nxt.r7_match = 1'b1;
            end else begin
              fl_nxt.r7_match = 1'b0;
            end
          end else if (fl_nxt.res_scan) begin
            fl_nxt.res_scan = 1'b0;
            ras_nxt         = 5'd0;
            rbase_nxt       = 3'd0;
          end else begin
            ras_nxt = ras_nxt + 5'd1;
            if (ras_nxt == 5'd0) begin
              if ({1'b0, line_nxt} == regs_r[R_VDISP]) pend_v_nxt = 1'b0;
              if ({1'b0, line_nxt} == regs_r[R_VSPOS]) begin
                if (last_end_nxt >= 8'd2 && !fl_nxt.r7_match) begin
                  fl_nxt.res_vsync = 1'b0;
                  if (!fl_nxt.in_vsync) begin
                    vswc_nxt        = 5'd0;
                    fl_nxt.in_vsync = 1'b1;
                    blank_nxt       = BLANK_LINES;
                    ev_vstart       = 1'b1;
                  end
                end
                fl_nxt.r7_match = 1'b1;
              end else begin
                fl_nxt.r7_match = 1'b0;
              end
            end
            rbase_nxt = rbase_nxt + 3'd1;
          end
          sl_nxt = SL_ONE;

          // Raster match against R9
          ras_match = ({3'd0, ras_nxt} == regs_r[R_MAXRAS]);
          if (ras_match) begin
            fl_nxt.res_scan = 1'b1;
            mr_nxt          = MR_ONE;
          end
          fl_nxt.r9_match = ras_match;

          // End of the total-adjust lines
          if (fl_nxt.in_vta && ras_nxt == adjust_nxt) begin
            fl_nxt.in_vta    = 1'b0;
            fl_nxt.res_frame = 1'b0;
            fl_nxt.res_scan  = 1'b0;
            fl_nxt.res_char  = 1'b0;
            ras_nxt          = 5'd0;
            rbase_nxt        = 3'd0;
            line_nxt         = 7'd0;
            pend_v_nxt       = 1'b1;
            la_cur_nxt       = la_req_nxt;
            la_next_nxt      = la_req_nxt;
            if ({1'b0, line_nxt} == regs_r[R_VDISP]) pend_v_nxt = 1'b0;
            if ({1'b0, line_nxt} == regs_r[R_VSPOS]) begin
              if (last_end_nxt >= 8'd2 && !fl_nxt.r7_match) begin
                fl_nxt.res_vsync = 1'b0;
                if (!fl_nxt.in_vsync) begin
                  vswc_nxt        = 5'd0;
                  fl_nxt.in_vsync = 1'b1;
                  blank_nxt       = BLANK_LINES;
                  ev_vstart       = 1'b1;
                end
              end
              fl_nxt.r7_match = 1'b1;
            end else begin
              fl_nxt.r7_match = 1'b0;
            end
            if (regs_r[R_MAXRAS] == 8'd0) fl_nxt.res_scan = 1'b1;
          end

          // Next character row
          if (fl_nxt.res_char) begin
            line_nxt = line_nxt + 7'd1;
            if (line_nxt == 7'd0) begin
              pend_v_nxt  = 1'b1;
              la_cur_nxt  = la_req_nxt;
              la_next_nxt = la_req_nxt;
            end
            if ({1'b0, line_nxt} == regs_r[R_VDISP]) pend_v_nxt = 1'b0;
            if ({1'b0, line_nxt} == regs_r[R_VSPOS]) begin
              if (last_end_nxt >= 8'd2 && !fl_nxt.r7_match) begin
                fl_nxt.res_vsync = 1'b0;
                if (!fl_nxt.in_vsync) begin
                  vswc_nxt        = 5'd0;
                  fl_nxt.in_vsync = 1'b1;
                  blank_nxt       = BLANK_LINES;
                  ev_vstart       = 1'b1;
                end
              end
              fl_nxt.r7_match = 1'b1;
            end else begin
              fl_nxt.r7_match = 1'b0;
            end
          end

          // Vertical sync end and scan line check
          if (fl_nxt.in_vsync) begin
            if (fl_nxt.res_vsync) begin
              fl_nxt.in_vsync  = 1'b0;
              fl_nxt.res_vsync = 1'b0;
              ev_check         = CHK_MAX;
            end else begin
              ev_check = CHK_MIN;
            end
          end else begin
            ev_check = CHK_MAX;
          end
        end

        // Horizontal display window
        if (char_nxt == {6'd0, h_start_nxt}) pend_h_nxt = pend_h_nxt | 2'b01;
        if (char_nxt == h_end_nxt) pend_h_nxt = pend_h_nxt & 2'b10;
      end

      CMD_SELECT: sel_nxt = in_ch.data[4:0];

      CMD_WRITE: begin
        if (!sel_r[4]) begin
          case (sel_r[3:0])
            R_HTOTAL: regs_nxt[R_HTOTAL] = wr_val;
            R_HDISP: begin
              regs_nxt[R_HDISP] = wr_val;
              pend_h_nxt        = pend_h_nxt | 2'b10;
              if (skew == 2'd3) begin
                pend_h_nxt = pend_h_nxt & 2'b01;
              end else begin
                h_start_nxt = skew;
                h_end_nxt   = {6'd0, skew} + wr_val;
              end
            end
            R_HSPOS: regs_nxt[R_HSPOS] = wr_val;
            R_SYNCW: regs_nxt[R_SYNCW] = wr_val;
            R_VTOTAL: begin
              regs_nxt[R_VTOTAL] = {1'b0, wr_val[6:0]};
              if (mr_r == MR_TWO && line_r == wr_val[6:0] &&
                  {3'd0, ras_r} == regs_r[R_MAXRAS])
                fl_nxt.start_vta = 1'b1;
            end
            R_VADJ: regs_nxt[R_VADJ] = {3'd0, wr_val[4:0]};
            R_VDISP: begin
              regs_nxt[R_VDISP] = {1'b0, wr_val[6:0]};
              if (line_r == wr_val[6:0]) pend_v_nxt = 1'b0;
            end
            R_VSPOS: begin
              regs_nxt[R_VSPOS] = {1'b0, wr_val[6:0]};
              if (line_r == wr_val[6:0]) begin
                if (!fl_r.r7_match) begin
                  fl_nxt.r7_match = 1'b1;
                  if (char_r >= 8'd2) begin
                    fl_nxt.res_vsync = 1'b0;
                    if (!fl_r.in_vsync) begin
                      vswc_nxt        = 5'd0;
                      fl_nxt.in_vsync = 1'b1;
                      blank_nxt       = BLANK_LINES;
                      ev_vstart       = 1'b1;
                    end
                  end
                end
              end else begin
                fl_nxt.r7_match = 1'b0;
              end
            end
            R_SKEW: begin
              regs_nxt[R_SKEW] = wr_val;
              pend_h_nxt       = pend_h_nxt | 2'b10;
              if (wr_val[5:4] == 2'd3) begin
                pend_h_nxt = pend_h_nxt & 2'b01;
              end else begin
                h_start_nxt = wr_val[5:4];
                h_end_nxt   = {6'd0, wr_val[5:4]} + regs_r[R_HDISP];
              end
            end
            R_MAXRAS: begin
              regs_nxt[R_MAXRAS] = {3'd0, wr_val[4:0]};
              ras_match          = (ras_r == wr_val[4:0]);
              if (ras_match) fl_nxt.res_scan = 1'b1;
              if (fl_r.r9_match != ras_match) begin
                fl_nxt.r9_match = ras_match;
                if (ras_match) mr_nxt = MR_ONE;
              end
              if (ras_match) begin
                if (char_r == regs_r[R_HDISP]) la_next_nxt = fetch_sum;
                if (char_r == regs_r[R_HTOTAL]) fl_nxt.res_char = 1'b1;
                if (!fl_r.start_vta) fl_nxt.res_scan = 1'b1;
              end else if (!fl_r.in_vta) begin
                fl_nxt.res_scan = 1'b0;
              end
            end
            R_CURST:  regs_nxt[R_CURST]  = {1'b0, wr_val[6:0]};
            R_CUREND: regs_nxt[R_CUREND] = {3'd0, wr_val[4:0]};
            R_ADDRH: begin
              regs_nxt[R_ADDRH] = {2'd0, wr_val[5:0]};
              la_req_nxt        = {wr_val[5:0], regs_r[R_ADDRL]};
            end
            R_ADDRL: begin
              regs_nxt[R_ADDRL] = wr_val;
              la_req_nxt        = {regs_r[R_ADDRH][5:0], wr_val};
            end
            R_CURH: regs_nxt[R_CURH] = {2'd0, wr_val[5:0]};
            R_CURL: regs_nxt[R_CURL] = wr_val;
            default: ;
          endcase
        end
      end

      CMD_READ: begin
        // Only the start address and cursor address registers read back
        if (sel_r[4:2] == 3'b011) rv = regs_r[sel_r[3:0]];
      end

      default: ;
    endcase
  end

  // Update the controller state on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r     <= REG_RESET;
      sel_r      <= 5'd0;
      char_r     <= 8'd0;
      ras_r      <= 5'd0;
      line_r     <= 7'd0;
      hsw_r      <= 4'd0;
      vswc_r     <= 5'd0;
      la_cur_r   <= 14'd0;
      la_next_r  <= 14'd0;
      la_req_r   <= 14'h3000;
      rbase_r    <= 3'd0;
      fl_r       <= '0;
      sl_r       <= SL_IDLE;
      mr_r       <= MR_IDLE;
      last_end_r <= 8'd0;
      h_start_r  <= 2'd0;
      h_end_r    <= 8'd40;
      adjust_r   <= 5'd0;
      pend_v_r   <= 1'b1;
      cur_v_r    <= 1'b1;
      pend_h_r   <= 2'd3;
      cur_h_r    <= 2'd3;
      blank_r    <= 5'd0;
      video_r    <= 16'd0;
    end else if (accept) begin
      regs_r     <= regs_nxt;
      sel_r      <= sel_nxt;
      char_r     <= char_nxt;
      ras_r      <= ras_nxt;
      line_r     <= line_nxt;
      hsw_r      <= hsw_nxt;
      vswc_r     <= vswc_nxt;
      la_cur_r   <= la_cur_nxt;
      la_next_r  <= la_next_nxt;
      la_req_r   <= la_req_nxt;
      rbase_r    <= rbase_nxt;
      fl_r       <= fl_nxt;
      sl_r       <= sl_nxt;
      mr_r       <= mr_nxt;
      last_end_r <= last_end_nxt;
      h_start_r  <= h_start_nxt;
      h_end_r    <= h_end_nxt;
      adjust_r   <= adjust_nxt;
      pend_v_r   <= pend_v_nxt;
      cur_v_r    <= cur_v_nxt;
      pend_h_r   <= pend_h_nxt;
      cur_h_r    <= cur_h_nxt;
      blank_r    <= blank_nxt;
      video_r    <= video_nxt;
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_rv_r     <= rv;
      out_video_r  <= video_nxt;
      out_hsync_r  <= fl_nxt.in_hsync;
      out_vsync_r  <= fl_nxt.in_vsync;
      out_ven_r    <= cur_v_nxt;
      out_hen_r    <= cur_h_nxt;
      out_blank_r  <= blank_nxt;
      out_mon_r    <= ev_mon;
      out_hend_r   <= ev_hend;
      out_vstart_r <= ev_vstart;
      out_mode_r   <= ev_mode;
      out_check_r  <= ev_check;
    end
  end

  assign out_ch.valid               = out_valid_r;
  assign out_ch.read_value          = out_rv_r;
  assign out_ch.video_address       = out_video_r;
  assign out_ch.hsync_active        = out_hsync_r;
  assign out_ch.vsync_active        = out_vsync_r;
  assign out_ch.vertical_enable     = out_ven_r;
  assign out_ch.horizontal_enable   = out_hen_r;
  assign out_ch.blank_lines_left    = out_blank_r;
  assign out_ch.monitor_hsync_event = out_mon_r;
  assign out_ch.hsync_end_pulse     = out_hend_r;
  assign out_ch.vsync_start_pulse   = out_vstart_r;
  assign out_ch.mode_change_pulse   = out_mode_r;
  assign out_ch.scanline_check      = out_check_r;

endmodule
`default_nettype wire

// ===== rtl/crtc0_checker.sv =====
// Port-level checks for the CRT controller and their binding
`default_nettype none
`include "crt_controller_type0_defines.svh"
module crtc0_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] video_address,
  input wire logic        hsync_active,
  input wire logic        vsync_active,
  input wire logic [4:0]  blank_lines_left,
  input wire logic        hsync_end_pulse,
  input wire logic        vsync_start_pulse
);
  import crtc0_pkg::*;

  // An empty result register always takes a word
  `CRTC0_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready, "input stalled with no word pending")

  // A stalled word holds
  `CRTC0_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(video_address), "stalled word changed")

  // The hsync end pulse leaves hsync off
  `CRTC0_ASSERT_NOW(a_hend_off, out_valid && hsync_end_pulse, !hsync_active, "hsync still on at its end")

  // Vsync entry loads the full blanking count
  `CRTC0_ASSERT_NOW(a_vstart_blank, out_valid && vsync_start_pulse, vsync_active && blank_lines_left == BLANK_LINES, "vsync entry state wrong")

endmodule

bind crt_controller_type0 crtc0_checker u_crtc0_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .video_address    (out_ch.video_address),
  .hsync_active     (out_ch.hsync_active),
  .vsync_active     (out_ch.vsync_active),
  .blank_lines_left (out_ch.blank_lines_left),
  .hsync_end_pulse  (out_ch.hsync_end_pulse),
  .vsync_start_pulse(out_ch.vsync_start_pulse)
);
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the CRT controller: command words in, one result word out each
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import crtc0_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int RANDOM_WORDS = 1850;

  typedef struct packed {
    logic [7:0]  rv;
    logic [15:0] vaddr;
    logic        hs;
    logic        vs;
    logic        ve;
    logic [1:0]  he;
    logic [4:0]  blank;
    logic [1:0]  mon;
    logic        hend;
    logic        vstart;
    logic        mode;
    logic [1:0]  chk;
  } crtc_word_t;

  typedef struct {
    cmd_t       cmd;
    logic [7:0] data;
    bit         typed;
    logic [7:0] rv;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  crtc0_in_if  in_if();
  crtc0_out_if out_if();

  crt_controller_type0 dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if.sink),
    .out_ch(out_if.source)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // controller model state
  logic [7:0]  m_regs [16];
  logic [4:0]  m_sel;
  logic [7:0]  m_chr;
  logic [4:0]  m_ras;
  logic [6:0]  m_line;
  logic [3:0]  m_hsw;
  logic [4:0]  m_vsw;
  logic [15:0] m_addr_cur, m_addr_nxt, m_addr_req;
  logic [15:0] m_ras_base;
  flags_t      m_fl;
  sl_t         m_sl;
  mr_t         m_mr;
  logic [7:0]  m_last_end, m_h_start, m_h_end, m_adjust;
  logic        m_pend_v, m_cur_v;
  logic [1:0]  m_pend_h, m_cur_h;
  logic [4:0]  m_blank;
  logic [15:0] m_vaddr;
  logic [1:0]  ev_mon, ev_chk;
  logic        ev_hend, ev_vstart, ev_mode;

  crtc_word_t pending_results [$];
  int         errors = 0;
  bit         quiet_in = 1'b0;
  bit         quiet_out = 1'b0;
  int         idle_cnt = 0;

  function automatic void start_vsync();
    m_fl.res_vsync = 1'b0;
    if (!m_fl.in_vsync) begin
      m_vsw = '0;
      m_fl.in_vsync = 1'b1;
      m_blank = BLANK_LINES;
      ev_vstart = 1'b1;
    end
  endfunction

  function automatic void mode_pulse();
    if (m_fl.had_hsync) begin
      m_fl.had_hsync = 1'b0;
      ev_mode = 1'b1;
    end
  endfunction

  // advance hsync width and raise the monitor events
  function automatic void step_hsync();
    if (m_hsw == m_regs[R_SYNCW][3:0]) begin
      ev_hend = 1'b1;
      m_fl.in_hsync = 1'b0;
      if (m_blank != 0) m_blank = m_blank - 1'b1;
      mode_pulse();
      if (m_fl.in_mon_hsync) begin
        m_fl.in_mon_hsync = 1'b0;
        ev_mon = MON_END;
      end
    end else begin
      m_hsw = m_hsw + 1'b1;
      if (m_hsw == 4'd3) begin
        m_fl.in_mon_hsync = 1'b1;
        ev_mon = MON_START;
      end else if (m_hsw == 4'd7) begin
        mode_pulse();
        m_fl.in_mon_hsync = 1'b0;
        ev_mon = MON_END;
      end
    end
  endfunction

  function automatic void check_line();
    if ({1'b0, m_line} == m_regs[R_VDISP]) m_pend_v = 1'b0;
    if ({1'b0, m_line} == m_regs[R_VSPOS]) begin
      if (m_last_end >= 2 && !m_fl.r7_match) start_vsync();
      m_fl.r7_match = 1'b1;
    end else begin
      m_fl.r7_match = 1'b0;
    end
  endfunction

  function automatic void new_line();
    if (m_line == 0) begin
      m_pend_v = 1'b1;
      m_addr_cur = m_addr_req;
      m_addr_nxt = m_addr_req;
    end
    check_line();
  endfunction

  function automatic void frame_restart();
    m_fl.in_vta = 1'b0;
    m_fl.res_frame = 1'b0;
    m_fl.res_scan = 1'b0;
    m_fl.res_char = 1'b0;
    m_ras = '0;
    m_ras_base = '0;
    m_line = '0;
    new_line();
  endfunction

  function automatic void apply_skew();
    logic [1:0] skew;
    skew = m_regs[R_SKEW][5:4];
    m_pend_h = m_pend_h | 2'b10;
    if (skew == 2'd3) begin
      m_pend_h = m_pend_h & 2'b01;
    end else begin
      m_h_start = {6'd0, skew};
      m_h_end = {6'd0, skew} + m_regs[R_HDISP];
    end
  endfunction

  // register write with its immediate side effects
  function automatic void reg_write(logic [4:0] r, logic [7:0] v);
    bit hit;
    if (r[4]) return;
    case (r[3:0])
      R_HTOTAL, R_HSPOS, R_SYNCW, R_CURL: m_regs[r[3:0]] = v;
      R_HDISP, R_SKEW: begin
        m_regs[r[3:0]] = v;
        apply_skew();
      end
      R_VTOTAL: begin
        m_regs[R_VTOTAL] = v & 8'h7f;
        if (m_mr == MR_TWO && {1'b0, m_line} == m_regs[R_VTOTAL]
            && {3'd0, m_ras} == m_regs[R_MAXRAS])
          m_fl.start_vta = 1'b1;
      end
      R_VADJ: m_regs[R_VADJ] = v & 8'h1f;
      R_VDISP: begin
        m_regs[R_VDISP] = v & 8'h7f;
        if ({1'b0, m_line} == m_regs[R_VDISP]) m_pend_v = 1'b0;
      end
      R_VSPOS: begin
        m_regs[R_VSPOS] = v & 8'h7f;
        if ({1'b0, m_line} == m_regs[R_VSPOS]) begin
          if (!m_fl.r7_match) begin
            m_fl.r7_match = 1'b1;
            if (m_chr >= 2) start_vsync();
          end
        end else begin
          m_fl.r7_match = 1'b0;
        end
      end
      R_MAXRAS: begin
        m_regs[R_MAXRAS] = v & 8'h1f;
        hit = ({3'd0, m_ras} == m_regs[R_MAXRAS]);
        if (hit) m_fl.res_scan = 1'b1;
        if (m_fl.r9_match != hit) begin
          m_fl.r9_match = hit;
          if (hit) m_mr = MR_ONE;
        end
        if (hit) begin
          if (m_chr == m_regs[R_HDISP]) m_addr_nxt = (m_addr_cur + m_chr) & 16'h3fff;
          if (m_chr == m_regs[R_HTOTAL]) m_fl.res_char = 1'b1;
          if (!m_fl.start_vta) m_fl.res_scan = 1'b1;
        end else if (!m_fl.in_vta) begin
          m_fl.res_scan = 1'b0;
        end
      end
      R_CURST: m_regs[R_CURST] = v & 8'h7f;
      R_CUREND: m_regs[R_CUREND] = v & 8'h1f;
      R_ADDRH, R_ADDRL: begin
        m_regs[r[3:0]] = (r[3:0] == R_ADDRH) ? (v & 8'h3f) : v;
        m_addr_req = {2'b00, m_regs[R_ADDRH][5:0], m_regs[R_ADDRL]};
      end
      R_CURH: m_regs[R_CURH] = v & 8'h3f;
      default: ;
    endcase
  endfunction

  // one character clock
  function automatic void char_tick();
    int unsigned idx, j, vsw_len;
    bit scan_done, hit;
    idx = (int'(m_addr_cur) + int'(m_chr)) & 32'h73ff;
    j = idx << 1;
    m_vaddr = 16'((j & 32'h7fe) | ((j & 32'h6000) << 1)) | m_ras_base;
    m_cur_v = m_pend_v;
    m_cur_h = m_pend_h;
    scan_done = 1'b0;

    if (m_chr == m_regs[R_HTOTAL]) begin
      m_last_end = m_chr;
      scan_done = 1'b1;
      m_chr = '0;
    end else begin
      m_chr = m_chr + 1'b1;
    end

    if (m_chr == m_regs[R_HTOTAL]) begin
      m_fl.res_char = ({3'd0, m_ras} == m_regs[R_MAXRAS]);
      if (m_fl.res_next) begin
        m_fl.res_next = 1'b0;
        m_fl.res_frame = 1'b1;
      end
      if (m_fl.start_vta) begin
        m_fl.start_vta = 1'b0;
        m_fl.in_vta = 1'b1;
      end
      if (m_fl.in_vta)
        m_fl.res_scan = ({3'd0, m_ras} == m_regs[R_MAXRAS])
                        && ({1'b0, m_line} == m_regs[R_VTOTAL]);
    end

    if (m_chr == m_regs[R_HDISP] && {3'd0, m_ras} == m_regs[R_MAXRAS])
      m_addr_nxt = (m_addr_cur + m_chr) & 16'h3fff;

    if (!m_fl.in_hsync) begin
      if (m_chr == m_regs[R_HSPOS]) begin
        m_fl.in_hsync = 1'b1;
        m_fl.had_hsync = 1'b1;
        m_hsw = '0;
        step_hsync();
      end
    end else begin
      step_hsync();
    end

    if (m_sl == SL_ONE) begin
      m_sl = SL_TWO;
    end else if (m_sl == SL_TWO) begin
      m_adjust = m_regs[R_VADJ];
      m_sl = SL_IDLE;
    end
    if (m_mr == MR_ONE) begin
      if ({3'd0, m_ras} == m_regs[R_MAXRAS] && {1'b0, m_line} == m_regs[R_VTOTAL]) begin
        m_fl.in_vta = 1'b0;
        m_fl.start_vta = 1'b1;
      end else begin
        m_fl.start_vta = 1'b0;
      end
      m_mr = MR_TWO;
    end else if (m_mr == MR_TWO) begin
      if (m_fl.start_vta && {1'b0, m_line} == m_regs[R_VTOTAL] && m_regs[R_VADJ] == 0)
        m_fl.res_next = 1'b1;
      m_mr = MR_IDLE;
    end

    if (scan_done) begin
      vsw_len = m_regs[R_SYNCW][7:4];
      if (vsw_len == 0) vsw_len = 16;
      m_addr_cur = m_addr_nxt;
      if (m_fl.in_vsync) begin
        m_vsw = m_vsw + 1'b1;
        if (m_vsw == vsw_len) begin
          m_vsw = '0;
          m_fl.res_vsync = 1'b1;
        end
      end
      if (m_fl.res_frame) begin
        frame_restart();
      end else if (m_fl.res_scan) begin
        m_fl.res_scan = 1'b0;
        m_ras = '0;
        m_ras_base = '0;
      end else begin
        m_ras = m_ras + 1'b1;
        if (m_ras == 0) check_line();
        m_ras_base = (m_ras_base + 16'h0800) & 16'h3800;
      end
      m_sl = SL_ONE;

      hit = ({3'd0, m_ras} == m_regs[R_MAXRAS]);
      if (hit) m_fl.res_scan = 1'b1;
      m_fl.r9_match = hit;
      if (hit) m_mr = MR_ONE;

      if (m_fl.in_vta && {3'd0, m_ras} == m_adjust) begin
        frame_restart();
        if (m_regs[R_MAXRAS] == 0) m_fl.res_scan = 1'b1;
      end
      if (m_fl.res_char) begin
        m_line = m_line + 1'b1;
        new_line();
      end
      if (m_fl.in_vsync) begin
        if (m_fl.res_vsync) begin
          m_fl.in_vsync = 1'b0;
          m_fl.res_vsync = 1'b0;
          ev_chk = CHK_MAX;
        end else begin
          ev_chk = CHK_MIN;
        end
      end else begin
        ev_chk = CHK_MAX;
      end
    end

    if (m_chr == m_h_start) m_pend_h = m_pend_h | 2'b01;
    if (m_chr == m_h_end) m_pend_h = m_pend_h & 2'b10;
  endfunction

  function automatic void model_reset();
    foreach (m_regs[i]) m_regs[i] = '0;
    m_fl = '0;
    m_sel = '0;
    m_chr = '0; m_ras = '0; m_line = '0; m_hsw = '0; m_vsw = '0;
    m_addr_cur = '0; m_addr_nxt = '0; m_addr_req = '0;
    m_ras_base = '0;
    m_sl = SL_IDLE;
    m_mr = MR_IDLE;
    m_last_end = '0; m_h_start = '0; m_h_end = '0; m_adjust = '0;
    m_blank = '0;
    m_vaddr = '0;
    m_pend_h = '0;
    reg_write(5'(R_SKEW), 8'd0);
    for (int r = 0; r < 16; r++)
      if (r != R_SKEW && r < 14 && !(r >= R_CURST && r <= R_CUREND))
        reg_write(5'(r), REG_RESET[r]);
    m_blank = '0;
    m_fl.in_hsync = 1'b0;
    m_pend_v = 1'b1; m_cur_v = 1'b1;
    m_pend_h = 2'd3; m_cur_h = 2'd3;
  endfunction

  // apply one command word and return the result it produces
  function automatic crtc_word_t model_step(cmd_t c, logic [7:0] d);
    crtc_word_t w;
    w.rv = '0;
    ev_mon = MON_NONE; ev_hend = 1'b0; ev_vstart = 1'b0; ev_mode = 1'b0; ev_chk = CHK_NONE;
    case (c)
      CMD_TICK:   char_tick();
      CMD_SELECT: m_sel = d[4:0];
      CMD_WRITE:  reg_write(m_sel, d);
      default:    if (m_sel > 11 && m_sel < 16) w.rv = m_regs[m_sel[3:0]];
    endcase
    w.vaddr = m_vaddr;
    w.hs = m_fl.in_hsync;
    w.vs = m_fl.in_vsync;
    w.ve = m_cur_v;
    w.he = m_cur_h;
    w.blank = m_blank;
    w.mon = ev_mon;
    w.hend = ev_hend;
    w.vstart = ev_vstart;
    w.mode = ev_mode;
    w.chk = ev_chk;
    return w;
  endfunction

  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // drive one word, predict its result on acceptance, then maybe idle
  task automatic send_word(cmd_t c, logic [7:0] d, bit typed = 1'b0, logic [7:0] rv = '0);
    crtc_word_t w;
    int gap;
    in_if.valid   <= 1'b1;
    in_if.command <= c;
    in_if.data    <= d;
    do @(posedge clk); while (!in_if.ready);
    w = model_step(c, d);
    if (typed) w.rv = rv;
    pending_results.push_back(w);
    gap = pick_gap(quiet_in);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load_reg(logic [3:0] r, logic [7:0] v);
    send_word(CMD_SELECT, {4'd0, r});
    send_word(CMD_WRITE, v);
  endtask

  // set a compact raster so frames, vsync and adjust come around often
  task automatic load_small_frame();
    load_reg(R_HTOTAL, 8'($urandom_range(3, 12)));
    load_reg(R_HDISP,  8'($urandom_range(1, 8)));
    load_reg(R_HSPOS,  8'($urandom_range(0, 10)));
    load_reg(R_SYNCW,  8'($urandom_range(0, 255)));
    load_reg(R_VTOTAL, 8'($urandom_range(0, 5)));
    load_reg(R_VADJ,   8'($urandom_range(0, 3)));
    load_reg(R_VDISP,  8'($urandom_range(0, 4)));
    load_reg(R_VSPOS,  8'($urandom_range(0, 4)));
    load_reg(R_SKEW,   8'($urandom));
    load_reg(R_MAXRAS, 8'($urandom_range(0, 3)));
  endtask

  function automatic void cmp_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s expected %0h actual %0h", $realtime, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // stall the result side and check each accepted word
  always @(posedge clk) begin
    crtc_word_t e;
    if (out_if.valid && out_if.ready && rst_n) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result word with nothing expected, expected none actual %0h",
                 $realtime, out_if.video_address);
        errors++;
      end else begin
        e = pending_results.pop_front();
        cmp_field("read_value", e.rv, out_if.read_value);
        cmp_field("video_address", e.vaddr, out_if.video_address);
        cmp_field("hsync_active", e.hs, out_if.hsync_active);
        cmp_field("vsync_active", e.vs, out_if.vsync_active);
        cmp_field("vertical_enable", e.ve, out_if.vertical_enable);
        cmp_field("horizontal_enable", e.he, out_if.horizontal_enable);
        cmp_field("blank_lines_left", e.blank, out_if.blank_lines_left);
        cmp_field("monitor_hsync_event", e.mon, out_if.monitor_hsync_event);
        cmp_field("hsync_end_pulse", e.hend, out_if.hsync_end_pulse);
        cmp_field("vsync_start_pulse", e.vstart, out_if.vsync_start_pulse);
        cmp_field("mode_change_pulse", e.mode, out_if.mode_change_pulse);
        cmp_field("scanline_check", e.chk, out_if.scanline_check);
      end
    end
    out_if.ready <= (pick_gap(quiet_out) == 0) || ($urandom_range(0, 3) == 0);
  end

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || !rst_n) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  initial begin
    stim_row_t rows [$];
    int n;
    int pick;
    int drain_at;
    in_if.valid   = 1'b0;
    in_if.command = CMD_TICK;
    in_if.data    = '0;
    out_if.ready  = 1'b0;
    model_reset();

    rows = '{
      '{CMD_READ,   8'h00, 1'b1, 8'h00},
      '{CMD_SELECT, 8'(R_ADDRH), 1'b0, 8'h00},
      '{CMD_READ,   8'h00, 1'b1, 8'h30},
      '{CMD_SELECT, 8'hEC, 1'b0, 8'h00},
      '{CMD_READ,   8'hFF, 1'b1, 8'h30},
      '{CMD_SELECT, 8'd16, 1'b0, 8'h00},
      '{CMD_WRITE,  8'hFF, 1'b0, 8'h00},
      '{CMD_READ,   8'h00, 1'b1, 8'h00},
      '{CMD_SELECT, 8'hFF, 1'b0, 8'h00},
      '{CMD_READ,   8'h00, 1'b1, 8'h00},
      '{CMD_TICK,   8'hFF, 1'b0, 8'h00},
      '{CMD_SELECT, 8'(R_ADDRH), 1'b0, 8'h00},
      '{CMD_WRITE,  8'hFF, 1'b0, 8'h00},
      '{CMD_READ,   8'h00, 1'b1, 8'h3F},
      '{CMD_SELECT, 8'(R_ADDRL), 1'b0, 8'h00},
      '{CMD_WRITE,  8'hFF, 1'b0, 8'h00},
      '{CMD_READ,   8'h00, 1'b1, 8'hFF},
      '{CMD_TICK,   8'h00, 1'b0, 8'h00},
      '{CMD_TICK,   8'h00, 1'b0, 8'h00},
      '{CMD_SELECT, 8'(R_SYNCW), 1'b0, 8'h00},
      '{CMD_WRITE,  8'h05, 1'b0, 8'h00},
      '{CMD_SELECT, 8'(R_SKEW), 1'b0, 8'h00},
      '{CMD_WRITE,  8'h30, 1'b0, 8'h00},
      '{CMD_SELECT, 8'(R_HDISP), 1'b0, 8'h00},
      '{CMD_WRITE,  8'hFF, 1'b0, 8'h00},
      '{CMD_SELECT, 8'(R_SKEW), 1'b0, 8'h00},
      '{CMD_WRITE,  8'h20, 1'b0, 8'h00},
      '{CMD_TICK,   8'h00, 1'b0, 8'h00}
    };

    // hold reset, then release
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words
    foreach (rows[i]) send_word(rows[i].cmd, rows[i].data, rows[i].typed, rows[i].rv);

    // random words, mostly ticks over a compact raster
    load_small_frame();
    n = 0;
    drain_at = 399;
    while (n < RANDOM_WORDS) begin
      if (n % 200 == 0) begin
        quiet_in = ($urandom_range(0, 3) == 0);
        quiet_out = ($urandom_range(0, 3) == 0);
      end
      // pause the sender until every expected result has come
      if (n >= drain_at) begin
        drain_at += 400;
        if (pending_results.size() != 0) begin
          in_if.valid <= 1'b0;
          while (pending_results.size() != 0) @(posedge clk);
        end
      end
      pick = $urandom_range(0, 99);
      if (pick < 84) begin
        send_word(CMD_TICK, 8'($urandom));
      end else if (pick < 94) begin
        load_reg(4'($urandom_range(0, 15)), ($urandom_range(0, 2) == 0) ?
                 8'($urandom) : 8'($urandom_range(0, 9)));
        n++;
      end else if (pick < 97) begin
        send_word(CMD_SELECT, 8'($urandom));
        send_word(CMD_READ, 8'($urandom));
        n++;
      end else if (pick < 99) begin
        send_word(CMD_WRITE, 8'($urandom));
      end else begin
        load_small_frame();
        n += 19;
      end
      n++;
    end
    in_if.valid <= 1'b0;

    // drain, then allow the output stage to settle
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== crt_controller_type0.f =====
+incdir+rtl
rtl/crtc0_pkg.sv
rtl/crtc0_if.sv
rtl/crt_controller_type0.sv
rtl/crtc0_checker.sv
tb/tb_top.sv
